/* rtl/mss_pkg.sv */
// Shared types, codes and constants for the multiplexed seven-segment meter.
// Used by every module of the block; depends on nothing else.
package mss_pkg;

   // Field widths.
   localparam int LIMIT_W = 16;
   localparam int CODE_W  = 10;
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 13;
   localparam int POS_W   = 2;
   localparam int SEG_W   = 8;
   localparam int SEL_W   = 4;
   localparam int DIGIT_W = 4;

   // Reset value of the sample limit register.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

   // Largest value the display path can hold.
   localparam logic [VALUE_W-1:0] VALUE_MAX = 13'd8191;

   // Beat kinds on the request channel.
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONV   = 2'd2;

   // Digit positions, in the order they are scanned.
   localparam logic [POS_W-1:0] POS_UNITS     = 2'd0;
   localparam logic [POS_W-1:0] POS_TENS      = 2'd1;
   localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd2;
   localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

   // One-hot digit enables.
   localparam logic [SEL_W-1:0] SEL_UNITS     = 4'b1000;
   localparam logic [SEL_W-1:0] SEL_TENS      = 4'b0100;
   localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 4'b0010;
   localparam logic [SEL_W-1:0] SEL_THOUSANDS = 4'b0001;

   // Decimal point bit of the segment word.
   localparam logic [SEG_W-1:0] DP_MASK = 8'b1000_0000;

   // Temperature scaling: floor(code * FULL_SCALE / ADC_STEPS), done as a
   // multiply by a rounded-up reciprocal. The shift leaves an error below
   // one part in ADC_STEPS over the whole code range, so the floor is exact.
   localparam int ADC_STEPS   = 1024;
   localparam int FULL_SCALE  = 5000;
   localparam int ScaleShift  = CODE_W + $clog2(ADC_STEPS) + 1;
   localparam longint unsigned ScaleMult =
      ((longint'(FULL_SCALE) << ScaleShift) + longint'(ADC_STEPS) - 1)
      / longint'(ADC_STEPS);
   localparam int SCALE_MULT_W = $clog2(ScaleMult + 1);
   localparam int SCALE_PROD_W = CODE_W + SCALE_MULT_W;

   // Reciprocals for splitting the shown value into decimal digits.
   // Each shift is wide enough to be exact for every VALUE_W-bit value.
   localparam int Div10Shift   = VALUE_W + 4;
   localparam int Div100Shift  = VALUE_W + 7;
   localparam int Div1000Shift = VALUE_W + 10;
   localparam int unsigned Div10Mult   = ((32'd1 << Div10Shift) + 9) / 10;
   localparam int unsigned Div100Mult  = ((32'd1 << Div100Shift) + 99) / 100;
   localparam int unsigned Div1000Mult = ((32'd1 << Div1000Shift) + 999) / 1000;

   // Request beat.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] pot_code;
      logic [CODE_W-1:0] conv_code;
   } req_item_type;

   // Response beat.
   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic [SEL_W-1:0] digit_select;
      logic             start_conversion;
   } rsp_item_type;

   // Display drive from the digit decoder.
   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic [SEL_W-1:0] digit_select;
   } disp_type;

   // Seven-segment pattern for one decimal digit, segments a..g in bits 0..6.
   function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      unique case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

/* rtl/mss_scale.sv */
// Temperature scaler: converter code to saturated display value.
// Depends on mss_pkg for the reciprocal constants and widths.
module mss_scale import mss_pkg::*; (
   input  logic [CODE_W-1:0]  conv_code,
   output logic [VALUE_W-1:0] scaled
);

   logic [SCALE_PROD_W-1:0] prod;
   logic [SCALE_PROD_W-1:0] quot;

   // Multiply by the reciprocal, drop the fraction bits, then saturate.
   always_comb begin
      prod = SCALE_PROD_W'(conv_code) * SCALE_PROD_W'(ScaleMult);
      quot = prod >> ScaleShift;
      if (quot > SCALE_PROD_W'(VALUE_MAX)) begin
         scaled = VALUE_MAX;
      end else begin
         scaled = VALUE_W'(quot);
      end
   end

endmodule

/* rtl/mss_digit.sv */
// Digit decoder: picks one decimal digit of the shown value and drives
// its segments and enable. Depends on mss_pkg for constants and seg_decode.
module mss_digit import mss_pkg::*; (
   input  logic [VALUE_W-1:0] value,
   input  logic [POS_W-1:0]   position,
   input  logic               temp_mode,
   output disp_type           disp
);

   logic [31:0]        prod10;
   logic [31:0]        prod100;
   logic [31:0]        prod1000;
   logic [VALUE_W-1:0] q10;
   logic [VALUE_W-1:0] q100;
   logic [VALUE_W-1:0] q1000;
   logic [DIGIT_W-1:0] digit0;
   logic [DIGIT_W-1:0] digit1;
   logic [DIGIT_W-1:0] digit2;
   logic [DIGIT_W-1:0] digit3;
   logic [DIGIT_W-1:0] digit;

   // Quotients by 10, 100 and 1000 in parallel through reciprocals.
   always_comb begin
      prod10   = 32'(value) * Div10Mult;
      prod100  = 32'(value) * Div100Mult;
      prod1000 = 32'(value) * Div1000Mult;
      q10      = VALUE_W'(prod10 >> Div10Shift);
      q100     = VALUE_W'(prod100 >> Div100Shift);
      q1000    = VALUE_W'(prod1000 >> Div1000Shift);
   end

   // Each digit is a quotient less ten times the next one up.
   always_comb begin
      digit0 = DIGIT_W'(value - VALUE_W'({q10, 3'b000} + {q10, 1'b0}));
      digit1 = DIGIT_W'(q10 - VALUE_W'({q100, 3'b000} + {q100, 1'b0}));
      digit2 = DIGIT_W'(q100 - VALUE_W'({q1000, 3'b000} + {q1000, 1'b0}));
      digit3 = DIGIT_W'(q1000);
   end

   // Select the scanned digit and light the decimal point on tens in
   // temperature mode.
   always_comb begin
      unique case (position)
         POS_UNITS: begin
            digit             = digit0;
            disp.digit_select = SEL_UNITS;
         end
         POS_TENS: begin
            digit             = digit1;
            disp.digit_select = SEL_TENS;
         end
         POS_HUNDREDS: begin
            digit             = digit2;
            disp.digit_select = SEL_HUNDREDS;
         end
         POS_THOUSANDS: begin
            digit             = digit3;
            disp.digit_select = SEL_THOUSANDS;
         end
      endcase
      disp.segments = seg_decode(digit);
      if (position == POS_TENS && temp_mode) begin
         disp.segments = disp.segments | DP_MASK;
      end
   end

endmodule

/* rtl/multiplexed_seven_segment_meter_core.sv */
// Top level of the four-digit multiplexed seven-segment meter.
// Depends on mss_pkg, mss_scale and mss_digit.
//
// Every request beat goes through an input register; a tick beat is then
// worked into a response register, so the block takes one beat per clock
// cycle unless a held tick is blocked by a stalled, full response register.
// A tick beat gives exactly one response beat (segments, one-hot
// digit enable, conversion request); button and conversion-complete beats
// and the unused kind give none. The cycle is set by the temperature
// scaling multiplier and by the digit split and segment decode, each one
// reciprocal multiply deep. The response register and the input register
// act as a two-entry pipe, so a new beat is taken while a response waits;
// stall on the response side reaches req_stall only when both are full.
// The sample limit is written through the csr port, which is always ready.
module multiplexed_seven_segment_meter_core import mss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   logic               in_valid_ff, in_valid_in;
   req_item_type       in_item_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;
   logic [LIMIT_W-1:0] sample_limit_ff;
   logic [LIMIT_W-1:0] tick_count_ff, tick_count_in;
   logic [POS_W-1:0]   digit_pos_ff, digit_pos_in;
   logic [VALUE_W-1:0] shown_value_ff, shown_value_in;
   logic [VALUE_W-1:0] scaled_temp_ff, scaled_temp_in;
   logic               temp_mode_ff, temp_mode_in;

   logic               accept;
   logic               is_tick;
   logic               out_free;
   logic               advance;
   logic               tick_fire;
   logic               reload;
   logic [VALUE_W-1:0] scaled;
   disp_type           disp;

   // Handshake: the held beat moves on unless it is a tick and the
   // response register is still occupied and stalled.
   always_comb begin
      is_tick   = (in_item_ff.kind == KIND_TICK);
      out_free  = !out_valid_ff || !rsp_stall;
      advance   = in_valid_ff && (!is_tick || out_free);
      tick_fire = advance && is_tick;
      req_stall = in_valid_ff && !advance;
      accept    = req_valid && !req_stall;
      csr_ready = 1'b1;
      rsp_valid = out_valid_ff;
      rsp_item  = out_item_ff;
   end

   // Datapath units.
   mss_scale u_scale (
      .conv_code (in_item_ff.conv_code),
      .scaled    (scaled)
   );

   mss_digit u_digit (
      .value     (shown_value_ff),
      .position  (digit_pos_ff),
      .temp_mode (temp_mode_ff),
      .disp      (disp)
   );

   // State update for the beat that leaves the input register.
   always_comb begin
      tick_count_in  = tick_count_ff;
      digit_pos_in   = digit_pos_ff;
      shown_value_in = shown_value_ff;
      scaled_temp_in = scaled_temp_ff;
      temp_mode_in   = temp_mode_ff;
      reload         = (tick_count_ff == sample_limit_ff);
      if (advance) begin
         priority if (in_item_ff.kind == KIND_BUTTON) begin
            temp_mode_in = !temp_mode_ff;
         end else if (in_item_ff.kind == KIND_CONV) begin
            if (temp_mode_ff) begin
               scaled_temp_in = scaled;
            end
         end else if (in_item_ff.kind == KIND_TICK) begin
            digit_pos_in = digit_pos_ff + POS_W'(1);
            if (reload) begin
               tick_count_in  = '0;
               shown_value_in = temp_mode_ff ? scaled_temp_ff
                                             : VALUE_W'(in_item_ff.pot_code);
            end else begin
               tick_count_in = tick_count_ff + LIMIT_W'(1);
            end
         end else begin
            tick_count_in = tick_count_ff;
         end
      end
   end

   // Response register contents and occupancy.
   always_comb begin
      out_item_in.segments         = disp.segments;
      out_item_in.digit_select     = disp.digit_select;
      out_item_in.start_conversion = reload && temp_mode_ff;
      if (tick_fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         sample_limit_ff <= LIMIT_RESET;
         tick_count_ff   <= '0;
         digit_pos_ff    <= POS_UNITS;
         shown_value_ff  <= '0;
         scaled_temp_ff  <= '0;
         temp_mode_ff    <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         tick_count_ff  <= tick_count_in;
         digit_pos_ff   <= digit_pos_in;
         shown_value_ff <= shown_value_in;
         scaled_temp_ff <= scaled_temp_in;
         temp_mode_ff   <= temp_mode_in;
         if (csr_valid && csr_ready) begin
            sample_limit_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (tick_fire) begin
         out_item_ff <= out_item_in;
      end
   end

`ifndef SYNTHESIS
   // A tick that leaves the input register is shown in the next cycle.
   a_tick_shown: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> rsp_valid)
      else $error("tick beat did not reach the response register");

   // Every tick moves the scan to the next digit.
   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> digit_pos_ff == $past(digit_pos_ff) + POS_W'(1))
      else $error("digit scan did not advance on a tick");

   // Back pressure only arises while a beat is held.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && is_tick && out_valid_ff && rsp_stall)
      else $error("request stalled without a blocked tick");

   // The decimal point is only ever lit on the tens digit.
   a_dp_tens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.segments[SEG_W-1] |-> rsp_item.digit_select == SEL_TENS)
      else $error("decimal point lit outside the tens digit");

   // Exactly one digit is enabled in every response.
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_item.digit_select))
      else $error("digit enable is not one-hot");
`endif

endmodule
